// ===== design/maf_pkg.sv =====
// ----------------------------------------------------------------------------
// maf_pkg
// Shared types, constants and hash functions of the multicast address filter.
// ----------------------------------------------------------------------------
package maf_pkg;

    localparam int MAX_ADDRESSES_DEF = 64;
    localparam int PERFECT_SLOTS_DEF = 31;

    localparam int ADDR_W   = 48;
    localparam int OPCODE_W = 2;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;
    localparam int CRC_W    = 32;
    localparam int HASH_W   = 8;
    localparam int BYTE_W   = 8;
    localparam int TABLE_BITS = 1 << HASH_W;
    localparam int ADDR_BYTES = ADDR_W / BYTE_W;
    localparam int BCNT_W     = $clog2(ADDR_BYTES);
    localparam int CFG_IDX_W  = 1;

    localparam logic [CRC_W-1:0]  CRC_POLY = 32'hEDB88320;
    localparam logic [CRC_W-1:0]  CRC_INIT = 32'hFFFFFFFF;
    localparam logic [HASH_W-1:0] HASH_INV = 8'hFF;

    localparam logic [CFG_IDX_W-1:0] REG_PROMISCUOUS     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_STATION_ADDRESS = 1'b1;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_CHECK  = 2'd2
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } status_t;

    typedef struct packed {
        logic    load_in;
        logic    idx_clr;
        logic    idx_inc;
        logic    mem_rd;
        logic    rd_next;
        logic    wr_tail;
        logic    wr_shift;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    crc_start;
        logic    crc_src_mem;
        logic    crc_step;
        logic    tbl_clr;
        logic    tbl_set;
        logic    res_load;
        logic    res_match;
        status_t res_status;
    } cmd_t;

    typedef struct packed {
        logic [OPCODE_W-1:0] op;
        logic full;
        logic over;
        logic idx_end;
        logic idx1_lt;
        logic hit;
        logic byte_last;
        logic tbl_bit;
    } stat_t;

    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
                                                   input logic [BYTE_W-1:0] data);
        logic [CRC_W-1:0] crc;
        logic fb;
        crc = crc_in;
        for (int j = 0; j < BYTE_W; j++)
        begin
            fb  = crc[0] ^ data[j];
            crc = crc >> 1;
            if (fb)
            begin
                crc = crc ^ CRC_POLY;
            end
        end
        return crc;
    endfunction

    function automatic logic [HASH_W-1:0] hash_of(input logic [CRC_W-1:0] crc);
        logic [HASH_W-1:0] idx;
        for (int k = 0; k < HASH_W; k++)
        begin
            idx[HASH_W-1-k] = crc[k];
        end
        return idx ^ HASH_INV;
    endfunction

endpackage

// ===== design/maf_ifs.sv =====
// ----------------------------------------------------------------------------
// maf interfaces
// Request, response and configuration channels of the multicast address filter.
// ----------------------------------------------------------------------------
interface maf_req_if;
    logic                          valid;
    logic                          ready;
    logic [maf_pkg::OPCODE_W-1:0]  opcode;
    logic [maf_pkg::ADDR_W-1:0]    address;

    modport source (output valid, output opcode, output address, input ready);
    modport sink   (input valid, input opcode, input address, output ready);
endinterface

interface maf_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          accepted;
    logic [maf_pkg::STATUS_W-1:0]  status;
    logic                          hash_mode;
    logic [maf_pkg::COUNT_W-1:0]   address_count;

    modport source (output valid, output accepted, output status, output hash_mode,
                    output address_count, input ready);
    modport sink   (input valid, input accepted, input status, input hash_mode,
                    input address_count, output ready);
endinterface

interface maf_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [maf_pkg::CFG_IDX_W-1:0]  reg_index;
    logic [maf_pkg::ADDR_W-1:0]     wdata;

    modport source (output valid, output reg_index, output wdata, input ready);
    modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

// ===== design/multicast_address_filter.sv =====
// ----------------------------------------------------------------------------
// multicast_address_filter
// Receive destination-address filter with exact list and CRC hash fallback.
// ----------------------------------------------------------------------------
// One transaction at a time. An add appends at the list tail and a remove
// searches the list and shifts the later entries down; when more than
// PERFECT_SLOTS entries remain, the hash table is rebuilt by one shared
// byte-serial CRC unit, one list entry after another. A check scans the
// list in exact mode, or hashes the address and reads the table bit in
// hash mode. Configuration writes are always ready.
module multicast_address_filter #(
    parameter int MAX_ADDRESSES = maf_pkg::MAX_ADDRESSES_DEF,
    parameter int PERFECT_SLOTS = maf_pkg::PERFECT_SLOTS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    maf_req_if.sink   req,
    maf_rsp_if.source rsp,
    maf_cfg_if.sink   cfg
);

    maf_pkg::cmd_t  cmd;
    maf_pkg::stat_t stat;

    assign cfg.ready = 1'b1;

    maf_controller u_ctl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    maf_datapath #(
        .MAX_ADDRESSES (MAX_ADDRESSES),
        .PERFECT_SLOTS (PERFECT_SLOTS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .req_opcode    (req.opcode),
        .req_address   (req.address),
        .cfg_write     (cfg.valid && cfg.ready),
        .cfg_index     (cfg.reg_index),
        .cfg_data      (cfg.wdata),
        .accepted      (rsp.accepted),
        .status        (rsp.status),
        .hash_mode     (rsp.hash_mode),
        .address_count (rsp.address_count)
    );

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(req.ready && rsp.valid))
        else $error("request ready while a response is pending");

    a_acc_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.accepted |-> rsp.status == maf_pkg::ST_OK)
        else $error("accepted with error status");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status == maf_pkg::ST_FULL |-> stat.full)
        else $error("full status while list not full");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready |=> $stable(rsp.address_count) && rsp.valid)
        else $error("response changed while stalled");
`endif

endmodule

// ===== design/maf_datapath.sv =====
// ----------------------------------------------------------------------------
// maf_datapath
// Address list memory, count, serial CRC unit, hash table and result registers.
// ----------------------------------------------------------------------------
module maf_datapath #(
    parameter int MAX_ADDRESSES = maf_pkg::MAX_ADDRESSES_DEF,
    parameter int PERFECT_SLOTS = maf_pkg::PERFECT_SLOTS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  maf_pkg::cmd_t                  cmd,
    output maf_pkg::stat_t                 stat,
    input  logic [maf_pkg::OPCODE_W-1:0]   req_opcode,
    input  logic [maf_pkg::ADDR_W-1:0]     req_address,
    input  logic                           cfg_write,
    input  logic [maf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [maf_pkg::ADDR_W-1:0]     cfg_data,
    output logic                           accepted,
    output logic [maf_pkg::STATUS_W-1:0]   status,
    output logic                           hash_mode,
    output logic [maf_pkg::COUNT_W-1:0]    address_count
);

    localparam int IW = $clog2(MAX_ADDRESSES);
    localparam int CW = $clog2(MAX_ADDRESSES + 1);

    logic [maf_pkg::ADDR_W-1:0]     mem [MAX_ADDRESSES];
    logic [maf_pkg::OPCODE_W-1:0]   op_reg;
    logic [maf_pkg::ADDR_W-1:0]     addr_reg;
    logic [maf_pkg::ADDR_W-1:0]     rd_data_reg;
    logic [maf_pkg::ADDR_W-1:0]     src_reg;
    logic [maf_pkg::CRC_W-1:0]      crc_reg;
    logic [maf_pkg::BCNT_W-1:0]     bcnt_reg;
    logic [CW-1:0]                  idx_reg;
    logic [CW-1:0]                  cnt_reg;
    logic [maf_pkg::TABLE_BITS-1:0] table_reg;
    logic                           promisc_reg;
    logic [maf_pkg::ADDR_W-1:0]     station_reg;
    logic                           acc_reg;
    logic [maf_pkg::STATUS_W-1:0]   status_reg;
    logic [IW-1:0]                  rd_addr;
    logic [maf_pkg::HASH_W-1:0]     hash_idx;
    logic                           acc_next;

    assign rd_addr  = cmd.rd_next ? idx_reg[IW-1:0] + IW'(1) : idx_reg[IW-1:0];
    assign hash_idx = maf_pkg::hash_of(crc_reg);
    assign acc_next = (op_reg == maf_pkg::OP_CHECK)
                      && (promisc_reg || addr_reg == station_reg || cmd.res_match);

    always_comb
    begin
        stat.op        = op_reg;
        stat.full      = cnt_reg >= CW'(MAX_ADDRESSES);
        stat.over      = cnt_reg > CW'(PERFECT_SLOTS);
        stat.idx_end   = idx_reg >= cnt_reg;
        stat.idx1_lt   = ({1'b0, idx_reg} + (CW + 1)'(1)) < {1'b0, cnt_reg};
        stat.hit       = rd_data_reg == addr_reg;
        stat.byte_last = bcnt_reg == maf_pkg::BCNT_W'(maf_pkg::ADDR_BYTES - 1);
        stat.tbl_bit   = table_reg[hash_idx];
    end

    // list memory
    always_ff @(posedge clk)
    begin
        if (cmd.wr_tail)
        begin
            mem[cnt_reg[IW-1:0]] <= addr_reg;
        end
        else if (cmd.wr_shift)
        begin
            mem[idx_reg[IW-1:0]] <= rd_data_reg;
        end
        if (cmd.mem_rd)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg   <= req_opcode;
            addr_reg <= req_address;
        end
        if (cmd.crc_start)
        begin
            src_reg <= cmd.crc_src_mem ? rd_data_reg : addr_reg;
            crc_reg <= maf_pkg::CRC_INIT;
        end
        else if (cmd.crc_step)
        begin
            src_reg <= src_reg << maf_pkg::BYTE_W;
            crc_reg <= maf_pkg::crc_byte(crc_reg,
                                         src_reg[maf_pkg::ADDR_W-1 -: maf_pkg::BYTE_W]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg     <= '0;
            cnt_reg     <= '0;
            bcnt_reg    <= '0;
            table_reg   <= '0;
            promisc_reg <= 1'b0;
            station_reg <= '0;
            acc_reg     <= 1'b0;
            status_reg  <= maf_pkg::ST_OK;
        end
        else
        begin
            if (cmd.idx_clr)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + CW'(1);
            end
            if (cmd.cnt_inc)
            begin
                cnt_reg <= cnt_reg + CW'(1);
            end
            else if (cmd.cnt_dec)
            begin
                cnt_reg <= cnt_reg - CW'(1);
            end
            if (cmd.crc_start)
            begin
                bcnt_reg <= '0;
            end
            else if (cmd.crc_step)
            begin
                bcnt_reg <= bcnt_reg + maf_pkg::BCNT_W'(1);
            end
            if (cmd.tbl_clr)
            begin
                table_reg <= '0;
            end
            else if (cmd.tbl_set)
            begin
                table_reg[hash_idx] <= 1'b1;
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    maf_pkg::REG_PROMISCUOUS:     promisc_reg <= cfg_data[0];
                    maf_pkg::REG_STATION_ADDRESS: station_reg <= cfg_data;
                    default:                      promisc_reg <= promisc_reg;
                endcase
            end
            if (cmd.res_load)
            begin
                acc_reg    <= acc_next;
                status_reg <= cmd.res_status;
            end
        end
    end

    assign accepted      = acc_reg;
    assign status        = status_reg;
    assign hash_mode     = stat.over;
    assign address_count = maf_pkg::COUNT_W'(cnt_reg);

endmodule

// ===== design/maf_controller.sv =====
// ----------------------------------------------------------------------------
// maf_controller
// Sequencer for add, remove, check and hash rebuild of the address filter.
// ----------------------------------------------------------------------------
module maf_controller (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  maf_pkg::stat_t stat,
    output maf_pkg::cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SRD,
        S_SCMP,
        S_SH_TEST,
        S_SH_WR,
        S_POSTUPD,
        S_RB_RD,
        S_RB_LD,
        S_RB_HASH,
        S_RB_SET,
        S_CHK_HASH,
        S_CHK_LOOK,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_ready_reg;
    logic   out_valid_reg;

    always_comb
    begin
        cmd        = '0;
        cmd.res_status = maf_pkg::ST_OK;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    cmd.idx_clr = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (stat.op)
                    maf_pkg::OP_ADD:
                    begin
                        if (stat.full)
                        begin
                            cmd.res_load   = 1'b1;
                            cmd.res_status = maf_pkg::ST_FULL;
                            state_next     = S_DONE;
                        end
                        else
                        begin
                            cmd.wr_tail = 1'b1;
                            cmd.cnt_inc = 1'b1;
                            state_next  = S_POSTUPD;
                        end
                    end
                    maf_pkg::OP_REMOVE:
                    begin
                        state_next = S_SRD;
                    end
                    maf_pkg::OP_CHECK:
                    begin
                        if (stat.over)
                        begin
                            cmd.crc_start = 1'b1;
                            state_next    = S_CHK_HASH;
                        end
                        else
                        begin
                            state_next = S_SRD;
                        end
                    end
                    default:
                    begin
                        cmd.res_load = 1'b1;
                        state_next   = S_DONE;
                    end
                endcase
            end
            S_SRD:
            begin
                if (stat.idx_end)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = (stat.op == maf_pkg::OP_REMOVE)
                                     ? maf_pkg::ST_NOT_FOUND : maf_pkg::ST_OK;
                    state_next     = S_DONE;
                end
                else
                begin
                    cmd.mem_rd = 1'b1;
                    state_next = S_SCMP;
                end
            end
            S_SCMP:
            begin
                if (stat.hit)
                begin
                    if (stat.op == maf_pkg::OP_REMOVE)
                    begin
                        state_next = S_SH_TEST;
                    end
                    else
                    begin
                        cmd.res_load  = 1'b1;
                        cmd.res_match = 1'b1;
                        state_next    = S_DONE;
                    end
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_SRD;
                end
            end
            S_SH_TEST:
            begin
                if (stat.idx1_lt)
                begin
                    cmd.mem_rd  = 1'b1;
                    cmd.rd_next = 1'b1;
                    state_next  = S_SH_WR;
                end
                else
                begin
                    cmd.cnt_dec = 1'b1;
                    state_next  = S_POSTUPD;
                end
            end
            S_SH_WR:
            begin
                cmd.wr_shift = 1'b1;
                cmd.idx_inc  = 1'b1;
                state_next   = S_SH_TEST;
            end
            S_POSTUPD:
            begin
                if (stat.over)
                begin
                    cmd.tbl_clr = 1'b1;
                    cmd.idx_clr = 1'b1;
                    state_next  = S_RB_RD;
                end
                else
                begin
                    cmd.res_load = 1'b1;
                    state_next   = S_DONE;
                end
            end
            S_RB_RD:
            begin
                if (stat.idx_end)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = S_DONE;
                end
                else
                begin
                    cmd.mem_rd = 1'b1;
                    state_next = S_RB_LD;
                end
            end
            S_RB_LD:
            begin
                cmd.crc_start   = 1'b1;
                cmd.crc_src_mem = 1'b1;
                state_next      = S_RB_HASH;
            end
            S_RB_HASH:
            begin
                cmd.crc_step = 1'b1;
                if (stat.byte_last)
                begin
                    state_next = S_RB_SET;
                end
            end
            S_RB_SET:
            begin
                cmd.tbl_set = 1'b1;
                cmd.idx_inc = 1'b1;
                state_next  = S_RB_RD;
            end
            S_CHK_HASH:
            begin
                cmd.crc_step = 1'b1;
                if (stat.byte_last)
                begin
                    state_next = S_CHK_LOOK;
                end
            end
            S_CHK_LOOK:
            begin
                cmd.res_load  = 1'b1;
                cmd.res_match = stat.tbl_bit;
                state_next    = S_DONE;
            end
            S_DONE:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            in_ready_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_ready_reg  <= state_next == S_IDLE;
            out_valid_reg <= state_next == S_DONE;
        end
    end

    assign in_ready  = in_ready_reg;
    assign out_valid = out_valid_reg;

endmodule
